>>> rtl/erm_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler rotation matrix core.
// Used by erm_front, erm_queue, erm_back and euler_rotation_matrix_core.
package erm_pkg;

   localparam int ANGLE_BITS  = 16;
   localparam int FRAC_BITS   = 14;
   localparam int OUT_W       = FRAC_BITS + 2;
   localparam int WORK_BITS   = 31;
   localparam int MAG_W       = 32;
   localparam int ACC_W       = 35;
   localparam int PROD_W      = 64;
   localparam int ROUNDS      = 7;
   localparam int SIN_TERMS   = 6;
   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_ANGLES  = 3;

   localparam logic [33:0]      PI_Q31   = 34'd6746518852;
   localparam logic [MAG_W-1:0] WORK_ONE = MAG_W'(1) << WORK_BITS;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_about_x;
      logic [ANGLE_BITS-1:0] angle_about_y;
      logic [ANGLE_BITS-1:0] angle_about_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] m00;
      logic signed [OUT_W-1:0] m01;
      logic signed [OUT_W-1:0] m02;
      logic signed [OUT_W-1:0] m10;
      logic signed [OUT_W-1:0] m11;
      logic signed [OUT_W-1:0] m12;
      logic signed [OUT_W-1:0] m20;
      logic signed [OUT_W-1:0] m21;
      logic signed [OUT_W-1:0] m22;
   } rsp_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sm_type;

   typedef struct packed {
      sm_type [NUM_ANGLES-1:0] sn;
      sm_type [NUM_ANGLES-1:0] cs;
   } trig_res_type;

   function automatic int sin_div(int k);
      return (2 * k) * (2 * k + 1);
   endfunction

   function automatic int cos_div(int k);
      return (2 * k - 1) * (2 * k);
   endfunction

   function automatic logic [MAG_W-1:0] round_q31(logic [PROD_W-1:0] p);
      logic [PROD_W-1:0] t;
      t = p + (PROD_W'(1) << (WORK_BITS - 1));
      return t[WORK_BITS+MAG_W-1:WORK_BITS];
   endfunction

   function automatic logic signed [ACC_W-1:0] sm_to_signed(sm_type v);
      logic signed [ACC_W-1:0] m;
      m = $signed({{(ACC_W-MAG_W){1'b0}}, v.mag});
      return v.neg ? -m : m;
   endfunction

   function automatic logic [OUT_W-1:0] to_out(logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] lim;
      m   = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      m   = (m + (ACC_W'(1) << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS);
      lim = ACC_W'(1) << FRAC_BITS;
      if (m > lim) begin
         m = lim;
      end
      return v[ACC_W-1] ? OUT_W'(-m) : OUT_W'(m);
   endfunction

endpackage

>>> rtl/erm_front.sv
// Front end: angle reduction and pipelined Taylor sine/cosine for three angles.
// Depends on erm_pkg.
module erm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  erm_pkg::req_type      req_data,
   input  logic                  queue_full,
   output logic                  res_valid,
   output erm_pkg::trig_res_type res_data
);

   localparam int NSTG = 5 + 4 * erm_pkg::ROUNDS;
   localparam int AB   = erm_pkg::ANGLE_BITS;
   localparam logic [AB-2:0] QUARTER = {1'b1, {(AB-2){1'b0}}};
   localparam logic [AB-2:0] HALF    = {2'b01, {(AB-3){1'b0}}};

   typedef struct packed {
      logic [1:0]                          q;
      logic                                swap;
      logic [AB-3:0]                       r;
      logic [erm_pkg::MAG_W-1:0]           ts;
      logic [erm_pkg::MAG_W-1:0]           tc;
      logic [erm_pkg::MAG_W-1:0]           x2;
      logic signed [erm_pkg::ACC_W-1:0]    s;
      logic signed [erm_pkg::ACC_W-1:0]    c;
      logic [erm_pkg::PROD_W-1:0]          ps;
      logic [erm_pkg::PROD_W-1:0]          pc;
   } trig_stage_type;

   trig_stage_type        pipe_ff [erm_pkg::NUM_ANGLES][NSTG];
   trig_stage_type        pipe_in [erm_pkg::NUM_ANGLES][NSTG];
   logic [NSTG-1:0]       vld_ff;
   logic                  res_valid_ff;
   erm_pkg::trig_res_type res_data_ff;
   erm_pkg::trig_res_type res_data_in;
   logic [AB-1:0]         ang [erm_pkg::NUM_ANGLES];
   logic                  front_ce;

   assign ang[0]    = req_data.angle_about_x;
   assign ang[1]    = req_data.angle_about_y;
   assign ang[2]    = req_data.angle_about_z;
   assign front_ce  = !res_valid_ff || !queue_full;
   assign req_stall = !front_ce;
   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;

   for (genvar g = 0; g < erm_pkg::NUM_ANGLES; g++) begin : g_angle

      // fold into the first octant
      always_comb begin
         trig_stage_type t;
         logic [AB-3:0]  r;
         logic [AB-2:0]  d;
         t      = '0;
         t.q    = ang[g][AB-1:AB-2];
         r      = ang[g][AB-3:0];
         d      = QUARTER - {1'b0, r};
         if ({1'b0, r} > HALF) begin
            t.r    = d[AB-3:0];
            t.swap = 1'b1;
         end else begin
            t.r    = r;
         end
         pipe_in[g][0] = t;
      end

      always_comb begin
         trig_stage_type t;
         t    = pipe_ff[g][0];
         t.ps = erm_pkg::PROD_W'(t.r) * erm_pkg::PROD_W'(erm_pkg::PI_Q31);
         pipe_in[g][1] = t;
      end

      always_comb begin
         trig_stage_type             t;
         logic [erm_pkg::PROD_W-1:0] tmp;
         t    = pipe_ff[g][1];
         tmp  = t.ps + (erm_pkg::PROD_W'(1) << (AB - 2));
         t.ts = erm_pkg::MAG_W'(tmp >> (AB - 1));
         t.s  = $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, t.ts});
         t.tc = erm_pkg::WORK_ONE;
         t.c  = $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, erm_pkg::WORK_ONE});
         pipe_in[g][2] = t;
      end

      always_comb begin
         trig_stage_type t;
         t    = pipe_ff[g][2];
         t.ps = erm_pkg::PROD_W'(t.ts) * erm_pkg::PROD_W'(t.ts);
         pipe_in[g][3] = t;
      end

      always_comb begin
         trig_stage_type t;
         t    = pipe_ff[g][3];
         t.x2 = erm_pkg::round_q31(t.ps);
         pipe_in[g][4] = t;
      end

      for (genvar k = 1; k <= erm_pkg::ROUNDS; k++) begin : g_round
         localparam int B  = 4 + 4 * (k - 1);
         localparam int KS = (k <= erm_pkg::SIN_TERMS) ? erm_pkg::sin_div(k) : 1;
         localparam int KC = erm_pkg::cos_div(k);
         localparam logic [erm_pkg::PROD_W-1:0] MS = (64'd1 << 32) / KS;
         localparam logic [erm_pkg::PROD_W-1:0] MC = (64'd1 << 32) / KC;

         always_comb begin
            trig_stage_type t;
            t    = pipe_ff[g][B];
            t.ps = erm_pkg::PROD_W'(t.ts) * erm_pkg::PROD_W'(t.x2);
            t.pc = erm_pkg::PROD_W'(t.tc) * erm_pkg::PROD_W'(t.x2);
            pipe_in[g][B+1] = t;
         end

         always_comb begin
            trig_stage_type t;
            t    = pipe_ff[g][B+1];
            t.ts = erm_pkg::round_q31(t.ps);
            t.tc = erm_pkg::round_q31(t.pc);
            pipe_in[g][B+2] = t;
         end

         always_comb begin
            trig_stage_type t;
            t    = pipe_ff[g][B+2];
            t.ps = erm_pkg::PROD_W'(t.ts) * MS;
            t.pc = erm_pkg::PROD_W'(t.tc) * MC;
            pipe_in[g][B+3] = t;
         end

         // quotient estimate is low by at most one
         always_comb begin
            trig_stage_type             t;
            logic [erm_pkg::MAG_W-1:0] qs;
            logic [erm_pkg::MAG_W-1:0] qc;
            logic [39:0]                rs;
            logic [39:0]                rc;
            t  = pipe_ff[g][B+3];
            qs = t.ps[63:32];
            qc = t.pc[63:32];
            rs = 40'(t.ts) - 40'(qs) * 40'(KS);
            rc = 40'(t.tc) - 40'(qc) * 40'(KC);
            if (rs >= 40'(KS)) begin
               qs = qs + 1'b1;
            end
            if (rc >= 40'(KC)) begin
               qc = qc + 1'b1;
            end
            if (k <= erm_pkg::SIN_TERMS) begin
               t.ts = qs;
               if (k % 2 == 1) begin
                  t.s = t.s - $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, qs});
               end else begin
                  t.s = t.s + $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, qs});
               end
            end
            t.tc = qc;
            if (k % 2 == 1) begin
               t.c = t.c - $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, qc});
            end else begin
               t.c = t.c + $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}}, qc});
            end
            pipe_in[g][B+4] = t;
         end
      end

      // clamp, unfold and apply quadrant
      always_comb begin
         trig_stage_type            t;
         logic [erm_pkg::MAG_W-1:0] sv;
         logic [erm_pkg::MAG_W-1:0] cv;
         logic [erm_pkg::MAG_W-1:0] tmp;
         t = pipe_ff[g][NSTG-1];
         if (t.s[erm_pkg::ACC_W-1]) begin
            sv = '0;
         end else if (t.s > $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}},
                                     erm_pkg::WORK_ONE})) begin
            sv = erm_pkg::WORK_ONE;
         end else begin
            sv = t.s[erm_pkg::MAG_W-1:0];
         end
         if (t.c[erm_pkg::ACC_W-1]) begin
            cv = '0;
         end else if (t.c > $signed({{(erm_pkg::ACC_W-erm_pkg::MAG_W){1'b0}},
                                     erm_pkg::WORK_ONE})) begin
            cv = erm_pkg::WORK_ONE;
         end else begin
            cv = t.c[erm_pkg::MAG_W-1:0];
         end
         if (t.swap) begin
            tmp = sv;
            sv  = cv;
            cv  = tmp;
         end
         unique case (t.q)
            2'd0: begin
               res_data_in.sn[g] = '{neg: 1'b0, mag: sv};
               res_data_in.cs[g] = '{neg: 1'b0, mag: cv};
            end
            2'd1: begin
               res_data_in.sn[g] = '{neg: 1'b0, mag: cv};
               res_data_in.cs[g] = '{neg: 1'b1, mag: sv};
            end
            2'd2: begin
               res_data_in.sn[g] = '{neg: 1'b1, mag: sv};
               res_data_in.cs[g] = '{neg: 1'b1, mag: cv};
            end
            default: begin
               res_data_in.sn[g] = '{neg: 1'b1, mag: cv};
               res_data_in.cs[g] = '{neg: 1'b0, mag: sv};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else if (front_ce) begin
         vld_ff       <= {vld_ff[NSTG-2:0], req_valid};
         res_valid_ff <= vld_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (front_ce) begin
         pipe_ff     <= pipe_in;
         res_data_ff <= res_data_in;
      end
   end

endmodule

>>> rtl/erm_queue.sv
// Short queue between the trig front end and the matrix back end.
// Depends on erm_pkg.
module erm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  erm_pkg::trig_res_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output erm_pkg::trig_res_type pop_data
);

   localparam int PTR_W = $clog2(erm_pkg::QUEUE_DEPTH);

   erm_pkg::trig_res_type mem_ff [erm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [PTR_W:0]        count_ff;
   logic [PTR_W:0]        count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = count_ff == (PTR_W+1)'(erm_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/erm_back.sv
// Back end: products of sines and cosines, sums, rounding and output register.
// Depends on erm_pkg.
module erm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  erm_pkg::trig_res_type q_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output erm_pkg::rsp_type      rsp_data
);

   localparam int NB = 6;
   localparam int NP = 12;
   localparam int NE = 9;

   logic [NB-1:0]                    vb_ff;
   logic                             rsp_valid_ff;
   erm_pkg::rsp_type                 rsp_data_ff;
   erm_pkg::rsp_type                 rsp_data_in;
   logic                             back_ce;

   erm_pkg::trig_res_type            b0_ff;
   erm_pkg::sm_type                  b1_sm_ff [6];
   logic [erm_pkg::PROD_W-1:0]       b1_pad_ff;
   logic [erm_pkg::PROD_W-1:0]       b1_pbd_ff;
   logic                             b1_adn_ff;
   logic                             b1_bdn_ff;
   erm_pkg::sm_type                  b2_sm_ff [6];
   erm_pkg::sm_type                  b2_ad_ff;
   erm_pkg::sm_type                  b2_bd_ff;
   erm_pkg::sm_type                  pa [NP];
   erm_pkg::sm_type                  pb [NP];
   logic [erm_pkg::PROD_W-1:0]       b3_prod_ff [NP];
   logic [NP-1:0]                    b3_neg_ff;
   erm_pkg::sm_type                  b3_d_ff;
   logic signed [erm_pkg::ACC_W-1:0] b4_term_ff [NP];
   logic signed [erm_pkg::ACC_W-1:0] b4_d_ff;
   logic signed [erm_pkg::ACC_W-1:0] b5_e_ff [NE];
   logic signed [erm_pkg::ACC_W-1:0] b5_e_in [NE];

   assign back_ce   = !rsp_valid_ff || !rsp_stall;
   assign pop       = back_ce && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a=cos x, b=sin x, c=cos y, d=sin y, e=cos z, f=sin z
   always_comb begin
      pa[0]  = b2_sm_ff[2]; pb[0]  = b2_sm_ff[4];
      pa[1]  = b2_sm_ff[2]; pb[1]  = b2_sm_ff[5];
      pa[2]  = b2_bd_ff;    pb[2]  = b2_sm_ff[4];
      pa[3]  = b2_sm_ff[0]; pb[3]  = b2_sm_ff[5];
      pa[4]  = b2_bd_ff;    pb[4]  = b2_sm_ff[5];
      pa[5]  = b2_sm_ff[0]; pb[5]  = b2_sm_ff[4];
      pa[6]  = b2_sm_ff[1]; pb[6]  = b2_sm_ff[2];
      pa[7]  = b2_ad_ff;    pb[7]  = b2_sm_ff[4];
      pa[8]  = b2_sm_ff[1]; pb[8]  = b2_sm_ff[5];
      pa[9]  = b2_ad_ff;    pb[9]  = b2_sm_ff[5];
      pa[10] = b2_sm_ff[1]; pb[10] = b2_sm_ff[4];
      pa[11] = b2_sm_ff[0]; pb[11] = b2_sm_ff[2];
   end

   always_comb begin
      b5_e_in[0] = b4_term_ff[0];
      b5_e_in[1] = -b4_term_ff[1];
      b5_e_in[2] = -b4_d_ff;
      b5_e_in[3] = b4_term_ff[3] - b4_term_ff[2];
      b5_e_in[4] = b4_term_ff[4] + b4_term_ff[5];
      b5_e_in[5] = -b4_term_ff[6];
      b5_e_in[6] = b4_term_ff[7] + b4_term_ff[8];
      b5_e_in[7] = b4_term_ff[10] - b4_term_ff[9];
      b5_e_in[8] = b4_term_ff[11];
   end

   always_comb begin
      rsp_data_in.m00 = erm_pkg::to_out(b5_e_ff[0]);
      rsp_data_in.m01 = erm_pkg::to_out(b5_e_ff[1]);
      rsp_data_in.m02 = erm_pkg::to_out(b5_e_ff[2]);
      rsp_data_in.m10 = erm_pkg::to_out(b5_e_ff[3]);
      rsp_data_in.m11 = erm_pkg::to_out(b5_e_ff[4]);
      rsp_data_in.m12 = erm_pkg::to_out(b5_e_ff[5]);
      rsp_data_in.m20 = erm_pkg::to_out(b5_e_ff[6]);
      rsp_data_in.m21 = erm_pkg::to_out(b5_e_ff[7]);
      rsp_data_in.m22 = erm_pkg::to_out(b5_e_ff[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (back_ce) begin
         vb_ff        <= {vb_ff[NB-2:0], q_valid};
         rsp_valid_ff <= vb_ff[NB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (back_ce) begin
         b0_ff       <= q_data;
         b1_sm_ff[0] <= b0_ff.cs[0];
         b1_sm_ff[1] <= b0_ff.sn[0];
         b1_sm_ff[2] <= b0_ff.cs[1];
         b1_sm_ff[3] <= b0_ff.sn[1];
         b1_sm_ff[4] <= b0_ff.cs[2];
         b1_sm_ff[5] <= b0_ff.sn[2];
         b1_pad_ff   <= erm_pkg::PROD_W'(b0_ff.cs[0].mag) * erm_pkg::PROD_W'(b0_ff.sn[1].mag);
         b1_pbd_ff   <= erm_pkg::PROD_W'(b0_ff.sn[0].mag) * erm_pkg::PROD_W'(b0_ff.sn[1].mag);
         b1_adn_ff   <= b0_ff.cs[0].neg ^ b0_ff.sn[1].neg;
         b1_bdn_ff   <= b0_ff.sn[0].neg ^ b0_ff.sn[1].neg;
         b2_sm_ff    <= b1_sm_ff;
         b2_ad_ff    <= '{neg: b1_adn_ff, mag: erm_pkg::round_q31(b1_pad_ff)};
         b2_bd_ff    <= '{neg: b1_bdn_ff, mag: erm_pkg::round_q31(b1_pbd_ff)};
         for (int i = 0; i < NP; i++) begin
            b3_prod_ff[i] <= erm_pkg::PROD_W'(pa[i].mag) * erm_pkg::PROD_W'(pb[i].mag);
            b3_neg_ff[i]  <= pa[i].neg ^ pb[i].neg;
            b4_term_ff[i] <= erm_pkg::sm_to_signed('{neg: b3_neg_ff[i],
                                 mag: erm_pkg::round_q31(b3_prod_ff[i])});
         end
         b3_d_ff     <= b2_sm_ff[3];
         b4_d_ff     <= erm_pkg::sm_to_signed(b3_d_ff);
         b5_e_ff     <= b5_e_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/euler_rotation_matrix_core.sv
// Euler angle triple to 3x3 rotation matrix in signed Q1.14.
// Throughput: one transaction per cycle; the front trig pipeline and the back
// product pipeline each stall on their own around a four-entry queue.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
// Depends on erm_pkg, erm_front, erm_queue and erm_back.
module euler_rotation_matrix_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  erm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output erm_pkg::rsp_type rsp_data
);

   logic                  front_valid;
   erm_pkg::trig_res_type front_data;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  queue_pop;
   erm_pkg::trig_res_type queue_data;

   erm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .res_valid  (front_valid),
      .res_data   (front_data)
   );

   erm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_data)
   );

   erm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (queue_not_empty),
      .q_data    (queue_data),
      .pop       (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
